@@ hdl/chre_pkg.sv @@
// ----------------------------------------------------------------------------
// chre_pkg
// Shared types, codes and match tables for the chunked response line
// extractor.
// ----------------------------------------------------------------------------
package chre_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } chre_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
    logic [2:0] error_code;
    logic       last;
  } chre_out_t;

  // Results produced by one accepted request: count and up to two entries.
  typedef struct packed {
    logic [1:0] n;
    chre_out_t  r0;
    chre_out_t  r1;
  } chre_push_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_STREAM = 2'd2
  } chre_phase_t;

  typedef enum logic [1:0] {
    CH_SIZE = 2'd0,
    CH_DATA = 2'd1,
    CH_CR   = 2'd2,
    CH_LF   = 2'd3
  } chre_chunk_t;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_EOL  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_HDR_LONG  = 3'd1;
  localparam logic [2:0] ERR_STATUS    = 3'd2;
  localparam logic [2:0] ERR_NOT_CHUNK = 3'd3;
  localparam logic [2:0] ERR_SIZE_LONG = 3'd4;
  localparam logic [2:0] ERR_ZERO_SIZE = 3'd5;

  localparam logic CFG_HEADER_LIMIT = 1'b0;
  localparam logic CFG_SIZE_LIMIT   = 1'b1;

  localparam logic [15:0] HEADER_LIMIT_RST = 16'd8192;
  localparam logic [11:0] SIZE_LIMIT_RST   = 12'd1024;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_BRACE = 8'h7B;
  localparam logic [7:0] CHR_C     = 8'h63;

  localparam logic [23:0] STATUS_200 = 24'h323030;
  localparam logic [31:0] HDR_END    = 32'h0D0A0D0A;

  localparam logic [4:0] TE_LEN = 5'd18;
  localparam logic [2:0] CK_LEN = 3'd7;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  // "transfer-encoding:" one character per position
  function automatic logic [7:0] te_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "t";
      5'd1:    c = "r";
      5'd2:    c = "a";
      5'd3:    c = "n";
      5'd4:    c = "s";
      5'd5:    c = "f";
      5'd6:    c = "e";
      5'd7:    c = "r";
      5'd8:    c = "-";
      5'd9:    c = "e";
      5'd10:   c = "n";
      5'd11:   c = "c";
      5'd12:   c = "o";
      5'd13:   c = "d";
      5'd14:   c = "i";
      5'd15:   c = "n";
      5'd16:   c = "g";
      5'd17:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "chunked"
  function automatic logic [7:0] ck_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "c";
      3'd1:    c = "h";
      3'd2:    c = "u";
      3'd3:    c = "n";
      3'd4:    c = "k";
      3'd5:    c = "e";
      3'd6:    c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Bit 4 set when the byte is a hex digit, low nibble holds its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, 4'(b - "0")};
    end else if (b >= "a" && b <= "f") begin
      r = {1'b1, 4'(b - "a" + 8'd10)};
    end else if (b >= "A" && b <= "F") begin
      r = {1'b1, 4'(b - "A" + 8'd10)};
    end
    return r;
  endfunction

  function automatic chre_out_t mk_byte(input logic [7:0] b);
    chre_out_t o;
    o.kind       = KIND_BYTE;
    o.payload    = b;
    o.error_code = ERR_NONE;
    o.last       = 1'b0;
    return o;
  endfunction

  function automatic chre_out_t mk_eol();
    chre_out_t o;
    o.kind       = KIND_EOL;
    o.payload    = 8'h00;
    o.error_code = ERR_NONE;
    o.last       = 1'b0;
    return o;
  endfunction

  function automatic chre_out_t mk_err(input logic [2:0] code);
    chre_out_t o;
    o.kind       = KIND_ERR;
    o.payload    = 8'h00;
    o.error_code = code;
    o.last       = 1'b0;
    return o;
  endfunction

endpackage

@@ hdl/chre_parser.sv @@
// ----------------------------------------------------------------------------
// chre_parser
// Header checks and chunk framing state, updated once per accepted request;
// produces up to two results for the queue in the same cycle.
// ----------------------------------------------------------------------------
module chre_parser import chre_pkg::*; #(
  parameter int SIZE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  chre_in_t    item,
  input  logic [15:0] header_limit,
  input  logic [11:0] size_line_limit,
  output chre_push_t  push
);

  chre_phase_t           phase_r, phase_nxt;
  chre_chunk_t           chunk_r, chunk_nxt;
  logic [15:0]           hcount_r, hcount_nxt;
  logic [31:0]           tail_r, tail_nxt;
  logic [4:0]            hpos_r, hpos_nxt;
  logic [2:0]            cpos_r, cpos_nxt;
  logic                  first_r, first_nxt;
  logic                  status_r, status_nxt;
  logic                  chunked_r, chunked_nxt;
  logic                  nopfx_r, nopfx_nxt;
  logic [11:0]           slen_r, slen_nxt;
  logic [SIZE_WIDTH-1:0] sval_r, sval_nxt;
  logic                  sf_cr_r, sf_cr_nxt;
  logic                  sf_stop_r, sf_stop_nxt;
  logic                  sf_long_r, sf_long_nxt;
  logic [SIZE_WIDTH-1:0] rem_r, rem_nxt;
  logic                  ln_start_r, ln_start_nxt;
  logic                  ln_pass_r, ln_pass_nxt;
  logic                  ln_cr_r, ln_cr_nxt;

  logic [7:0]            b;
  logic [7:0]            lc;
  logic [31:0]           tail_new;
  logic [2:0]            cp;
  logic [12:0]           cnt;
  logic [4:0]            hd;
  logic [SIZE_WIDTH+3:0] wide;
  logic [SIZE_WIDTH-1:0] rem_dec;

  // One size-line character: flag too long at the limit, else count it.
  function automatic logic [12:0] count_char(input logic [11:0] len, input logic lg,
                                             input logic [11:0] lim);
    logic [12:0] r;
    if (len >= lim) begin
      r = {1'b1, len};
    end else begin
      r = {lg, len + 12'd1};
    end
    return r;
  endfunction

  assign b  = item.data_byte;
  assign lc = (b inside {["A":"Z"]}) ? b + 8'd32 : b;

  always_comb begin
    phase_nxt    = phase_r;
    chunk_nxt    = chunk_r;
    hcount_nxt   = hcount_r;
    tail_nxt     = tail_r;
    hpos_nxt     = hpos_r;
    cpos_nxt     = cpos_r;
    first_nxt    = first_r;
    status_nxt   = status_r;
    chunked_nxt  = chunked_r;
    nopfx_nxt    = nopfx_r;
    slen_nxt     = slen_r;
    sval_nxt     = sval_r;
    sf_cr_nxt    = sf_cr_r;
    sf_stop_nxt  = sf_stop_r;
    sf_long_nxt  = sf_long_r;
    rem_nxt      = rem_r;
    ln_start_nxt = ln_start_r;
    ln_pass_nxt  = ln_pass_r;
    ln_cr_nxt    = ln_cr_r;
    push         = '0;
    tail_new     = {tail_r[23:0], b};
    cp           = 3'd0;
    cnt          = 13'd0;
    hd           = hex_digit(b);
    wide         = {sval_r, 4'd0} + (SIZE_WIDTH+4)'(hd[3:0]);
    rem_dec      = rem_r - SIZE_WIDTH'(1);

    if (acc) begin
      if (item.mode) begin
        phase_nxt    = PH_HEADER;
        chunk_nxt    = CH_SIZE;
        hcount_nxt   = 16'd0;
        tail_nxt     = 32'd0;
        hpos_nxt     = 5'd0;
        cpos_nxt     = 3'd0;
        first_nxt    = 1'b1;
        status_nxt   = 1'b0;
        chunked_nxt  = 1'b0;
        nopfx_nxt    = 1'b0;
        slen_nxt     = 12'd0;
        sval_nxt     = '0;
        sf_cr_nxt    = 1'b0;
        sf_stop_nxt  = 1'b0;
        sf_long_nxt  = 1'b0;
        rem_nxt      = '0;
        ln_start_nxt = 1'b1;
        ln_pass_nxt  = 1'b0;
        ln_cr_nxt    = 1'b0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (hcount_r >= header_limit) begin
              phase_nxt = PH_IDLE;
              push.n    = 2'd1;
              push.r0   = mk_err(ERR_HDR_LONG);
            end else begin
              hcount_nxt = hcount_r + 16'd1;
              tail_nxt   = tail_new;
              if (b == CHR_LF) begin
                first_nxt = 1'b0;
                nopfx_nxt = 1'b0;
                hpos_nxt  = 5'd0;
                cpos_nxt  = 3'd0;
              end else if (first_r) begin
                if (tail_new[23:0] == STATUS_200) status_nxt = 1'b1;
              end else if (!nopfx_r) begin
                if (hpos_r < TE_LEN) begin
                  if (lc == te_char(hpos_r)) hpos_nxt = hpos_r + 5'd1;
                  else nopfx_nxt = 1'b1;
                end else if (cpos_r < CK_LEN) begin
                  if (lc == ck_char(cpos_r)) cp = cpos_r + 3'd1;
                  else cp = (lc == CHR_C) ? 3'd1 : 3'd0;
                  cpos_nxt = cp;
                  if (cp == CK_LEN) chunked_nxt = 1'b1;
                end
              end
              if (tail_new == HDR_END) begin
                if (!status_nxt) begin
                  phase_nxt = PH_IDLE;
                  push.n    = 2'd1;
                  push.r0   = mk_err(ERR_STATUS);
                end else if (!chunked_nxt) begin
                  phase_nxt = PH_IDLE;
                  push.n    = 2'd1;
                  push.r0   = mk_err(ERR_NOT_CHUNK);
                end else begin
                  phase_nxt    = PH_STREAM;
                  chunk_nxt    = CH_SIZE;
                  slen_nxt     = 12'd0;
                  sval_nxt     = '0;
                  sf_cr_nxt    = 1'b0;
                  sf_stop_nxt  = 1'b0;
                  sf_long_nxt  = 1'b0;
                  rem_nxt      = '0;
                  ln_start_nxt = 1'b1;
                  ln_pass_nxt  = 1'b0;
                  ln_cr_nxt    = 1'b0;
                end
              end
            end
          end
          PH_STREAM: begin
            case (chunk_r)
              CH_SIZE: begin
                if (b == CHR_LF && sf_cr_r) begin
                  if (sf_long_r) begin
                    phase_nxt = PH_IDLE;
                    push.n    = 2'd1;
                    push.r0   = mk_err(ERR_SIZE_LONG);
                  end else if (sval_r == '0) begin
                    phase_nxt = PH_IDLE;
                    push.n    = 2'd1;
                    push.r0   = mk_err(ERR_ZERO_SIZE);
                  end else begin
                    rem_nxt      = sval_r;
                    chunk_nxt    = CH_DATA;
                    slen_nxt     = 12'd0;
                    sval_nxt     = '0;
                    sf_cr_nxt    = 1'b0;
                    sf_stop_nxt  = 1'b0;
                    sf_long_nxt  = 1'b0;
                    ln_start_nxt = 1'b1;
                    ln_pass_nxt  = 1'b0;
                    ln_cr_nxt    = 1'b0;
                  end
                end else begin
                  cnt = {sf_long_r, slen_r};
                  // a CR not followed by LF counts as a character now
                  if (sf_cr_r) cnt = count_char(cnt[11:0], cnt[12], size_line_limit);
                  if (b == CHR_CR) begin
                    sf_cr_nxt = 1'b1;
                  end else begin
                    sf_cr_nxt = 1'b0;
                    cnt = count_char(cnt[11:0], cnt[12], size_line_limit);
                  end
                  slen_nxt    = cnt[11:0];
                  sf_long_nxt = cnt[12];
                  if (!sf_stop_r) begin
                    if (!hd[4]) sf_stop_nxt = 1'b1;
                    else if (wide[SIZE_WIDTH+3:SIZE_WIDTH] != 4'd0) sval_nxt = '1;
                    else sval_nxt = wide[SIZE_WIDTH-1:0];
                  end
                end
              end
              CH_DATA: begin
                rem_nxt = rem_dec;
                if (rem_dec == '0) chunk_nxt = CH_CR;
                if (b == CHR_LF) begin
                  if (ln_pass_r) begin
                    push.n  = 2'd1;
                    push.r0 = mk_eol();
                  end
                  ln_start_nxt = 1'b1;
                  ln_pass_nxt  = 1'b0;
                  ln_cr_nxt    = 1'b0;
                end else if (ln_start_r) begin
                  ln_start_nxt = 1'b0;
                  ln_cr_nxt    = 1'b0;
                  ln_pass_nxt  = (b == CHR_BRACE);
                  if (b == CHR_BRACE) begin
                    push.n  = 2'd1;
                    push.r0 = mk_byte(b);
                  end
                end else if (ln_pass_r) begin
                  // release a held CR once it proves not to end the line
                  ln_cr_nxt = (b == CHR_CR);
                  if (ln_cr_r && b != CHR_CR) begin
                    push.n  = 2'd2;
                    push.r0 = mk_byte(CHR_CR);
                    push.r1 = mk_byte(b);
                  end else if (ln_cr_r) begin
                    push.n  = 2'd1;
                    push.r0 = mk_byte(CHR_CR);
                  end else if (b != CHR_CR) begin
                    push.n  = 2'd1;
                    push.r0 = mk_byte(b);
                  end
                end
              end
              CH_CR: begin
                if (b == CHR_CR) chunk_nxt = CH_LF;
              end
              CH_LF: begin
                if (b == CHR_LF) begin
                  if (ln_pass_r) begin
                    push.n  = 2'd1;
                    push.r0 = mk_eol();
                  end
                  ln_start_nxt = 1'b1;
                  ln_pass_nxt  = 1'b0;
                  ln_cr_nxt    = 1'b0;
                  chunk_nxt    = CH_SIZE;
                  rem_nxt      = '0;
                end
              end
              default: begin
                chunk_nxt = CH_SIZE;
              end
            endcase
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end

    if (push.n == 2'd1) push.r0.last = 1'b1;
    if (push.n == 2'd2) push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      chunk_r    <= CH_SIZE;
      hcount_r   <= 16'd0;
      tail_r     <= 32'd0;
      hpos_r     <= 5'd0;
      cpos_r     <= 3'd0;
      first_r    <= 1'b1;
      status_r   <= 1'b0;
      chunked_r  <= 1'b0;
      nopfx_r    <= 1'b0;
      slen_r     <= 12'd0;
      sval_r     <= '0;
      sf_cr_r    <= 1'b0;
      sf_stop_r  <= 1'b0;
      sf_long_r  <= 1'b0;
      rem_r      <= '0;
      ln_start_r <= 1'b1;
      ln_pass_r  <= 1'b0;
      ln_cr_r    <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      chunk_r    <= chunk_nxt;
      hcount_r   <= hcount_nxt;
      tail_r     <= tail_nxt;
      hpos_r     <= hpos_nxt;
      cpos_r     <= cpos_nxt;
      first_r    <= first_nxt;
      status_r   <= status_nxt;
      chunked_r  <= chunked_nxt;
      nopfx_r    <= nopfx_nxt;
      slen_r     <= slen_nxt;
      sval_r     <= sval_nxt;
      sf_cr_r    <= sf_cr_nxt;
      sf_stop_r  <= sf_stop_nxt;
      sf_long_r  <= sf_long_nxt;
      rem_r      <= rem_nxt;
      ln_start_r <= ln_start_nxt;
      ln_pass_r  <= ln_pass_nxt;
      ln_cr_r    <= ln_cr_nxt;
    end
  end

endmodule

@@ hdl/chre_result_fifo.sv @@
// ----------------------------------------------------------------------------
// chre_result_fifo
// Four-entry result queue taking up to two results per cycle and handing out
// one per cycle while the output does not stall.
// ----------------------------------------------------------------------------
module chre_result_fifo import chre_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  chre_push_t push,
  output logic       room_low,
  output logic       out_valid,
  input  logic       out_stall,
  output chre_out_t  out_data
);

  chre_out_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W:0]   count_r, count_nxt;
  logic                  pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // hold the input side unless two free slots remain
  assign room_low  = (count_r > (FIFO_PTR_W+1)'(FIFO_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + (FIFO_PTR_W+1)'(push.n) - (FIFO_PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) mem_r[wr_ptr_r + FIFO_PTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hdl/http_chunked_response_line_extractor_top.sv @@
// ----------------------------------------------------------------------------
// http_chunked_response_line_extractor_top
// Checks an HTTP response header, decodes chunked framing and streams out the
// lines of each chunk that start with an opening brace.
// ----------------------------------------------------------------------------
// One request is taken per clock: each byte (or restart) updates the header
// and chunk state in the cycle it is accepted, and the one or two results it
// causes enter a four-entry result queue, visible at the output from the next
// cycle. The input stalls only while that queue has fewer than two free
// slots, so the sustained rate is one request per cycle as long as the output
// side drains one result per cycle and at most one result per byte is made;
// a byte that releases a held CR makes two. Write the limit registers only
// while the block is idle. A restart clears all parsing state but keeps the
// limits; after an error the block ignores bytes until the next restart.
module http_chunked_response_line_extractor_top import chre_pkg::*; #(
  parameter int SIZE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  chre_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output chre_out_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] header_limit_r;
  logic [11:0] size_limit_r;
  logic        in_acc;
  logic        room_low;
  chre_push_t  push;

  assign in_stall = room_low;
  assign in_acc   = in_valid && !in_stall;

  // Limit registers: plain writes, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_limit_r <= HEADER_LIMIT_RST;
      size_limit_r   <= SIZE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HEADER_LIMIT: header_limit_r <= cfg_wdata;
        CFG_SIZE_LIMIT:   size_limit_r   <= cfg_wdata[11:0];
        default:          header_limit_r <= header_limit_r;
      endcase
    end
  end

  // Parse each accepted request and form its results
  chre_parser #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (in_acc),
    .item           (in_data),
    .header_limit   (header_limit_r),
    .size_line_limit(size_limit_r),
    .push           (push)
  );

  // Queue results so the input keeps flowing while the output stalls
  chre_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room_low (room_low),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

@@ tb/tb_http_chunked_response_line_extractor_top.sv @@
// ----------------------------------------------------------------------------
// tb_http_chunked_response_line_extractor_top
// Self-checking bench for the chunked response line extractor. Responses are
// built byte by byte and fed through the request channel. Most are
// well-formed, with random header case, chunk sizes, extensions, trailers and
// brace lines. The rest are broken or plain noise. A cycle-free predictor
// tracks the header and chunk state, and every accepted result is compared
// field by field, in order, with what it predicts. Both channels stall and
// idle in random bursts, except in the final stretch. The limit registers
// are swept across their extremes between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_http_chunked_response_line_extractor_top import chre_pkg::*;;

  localparam int SIZE_BITS = 32;

  // --------------------------------------------------------------------------
  // Predictor and result checker
  // --------------------------------------------------------------------------
  class chunk_line_tracker #(int SIZE_BITS = 32);
    chre_out_t   events_due[$];
    chre_out_t   held_ev;
    bit          held_on;
    logic [15:0] hdr_limit;
    logic [11:0] size_limit;
    chre_phase_t phase;
    chre_chunk_t chunk;
    logic [15:0] hdr_count;
    logic [31:0] tail;
    int          te_pos;
    int          ck_pos;
    bit          first_line, status_ok, chunked_seen, prefix_bad;
    logic [11:0] size_len;
    bit          size_cr, size_stop, size_long;
    logic [63:0] size_val;
    logic [63:0] remaining;
    bit          ln_start, ln_pass, ln_cr;
    string       te_word;
    string       ck_word;
    int          n_requests, n_restarts, n_results, n_lines, n_errors, n_fail;

    function new();
      te_word    = "transfer-encoding:";
      ck_word    = "chunked";
      hdr_limit  = HEADER_LIMIT_RST;
      size_limit = SIZE_LIMIT_RST;
      held_on    = 1'b0;
      begin_response();
      phase = PH_IDLE;
    endfunction

    function void set_limits(logic [15:0] hdr, logic [11:0] size);
      hdr_limit  = hdr;
      size_limit = size;
    endfunction

    // Hold back the newest result so the final one of a request can be marked.
    function void emit(logic [1:0] kind, logic [7:0] pay, logic [2:0] code);
      chre_out_t e;
      e.kind       = kind;
      e.payload    = pay;
      e.error_code = code;
      e.last       = 1'b0;
      if (held_on) events_due.push_back(held_ev);
      held_ev = e;
      held_on = 1'b1;
    endfunction

    function void stream_error(logic [2:0] code);
      phase = PH_IDLE;
      emit(KIND_ERR, 8'h00, code);
    endfunction

    function void clear_size();
      size_len  = '0;
      size_val  = '0;
      size_cr   = 1'b0;
      size_stop = 1'b0;
      size_long = 1'b0;
    endfunction

    function void open_line();
      ln_start = 1'b1;
      ln_pass  = 1'b0;
      ln_cr    = 1'b0;
    endfunction

    function void begin_response();
      phase        = PH_HEADER;
      chunk        = CH_SIZE;
      hdr_count    = '0;
      tail         = '0;
      te_pos       = 0;
      ck_pos       = 0;
      first_line   = 1'b1;
      status_ok    = 1'b0;
      chunked_seen = 1'b0;
      prefix_bad   = 1'b0;
      clear_size();
      remaining = '0;
      open_line();
    endfunction

    function void header_byte(logic [7:0] b);
      logic [7:0] lc;
      lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      if (hdr_count >= hdr_limit) begin
        stream_error(ERR_HDR_LONG);
        return;
      end
      hdr_count = hdr_count + 16'd1;
      tail      = {tail[23:0], b};
      if (b == CHR_LF) begin
        first_line = 1'b0;
        prefix_bad = 1'b0;
        te_pos     = 0;
        ck_pos     = 0;
      end else if (first_line) begin
        if (tail[23:0] == STATUS_200) status_ok = 1'b1;
      end else if (!prefix_bad) begin
        if (te_pos < te_word.len()) begin
          if (lc == te_word[te_pos]) te_pos++;
          else prefix_bad = 1'b1;
        end else if (ck_pos < ck_word.len()) begin
          if (lc == ck_word[ck_pos]) ck_pos++;
          else ck_pos = (lc == CHR_C) ? 1 : 0;
          if (ck_pos == ck_word.len()) chunked_seen = 1'b1;
        end
      end
      if (tail == HDR_END) begin
        if (!status_ok) stream_error(ERR_STATUS);
        else if (!chunked_seen) stream_error(ERR_NOT_CHUNK);
        else begin
          phase = PH_STREAM;
          chunk = CH_SIZE;
          clear_size();
          remaining = '0;
          open_line();
        end
      end
    endfunction

    function void count_size_char();
      if (size_len >= size_limit) size_long = 1'b1;
      else size_len = size_len + 12'd1;
    endfunction

    function void size_byte(logic [7:0] b);
      logic [63:0] d;
      logic [63:0] size_max;
      size_max = (64'd1 << SIZE_BITS) - 64'd1;
      if (b == CHR_LF && size_cr) begin
        if (size_long) stream_error(ERR_SIZE_LONG);
        else if (size_val == 0) stream_error(ERR_ZERO_SIZE);
        else begin
          remaining = size_val;
          chunk     = CH_DATA;
          clear_size();
          open_line();
        end
        return;
      end
      if (size_cr) count_size_char();
      if (b == CHR_CR) size_cr = 1'b1;
      else begin
        size_cr = 1'b0;
        count_size_char();
      end
      if (size_stop) return;
      if (b >= "0" && b <= "9") d = b - "0";
      else if (b >= "a" && b <= "f") d = b - "a" + 10;
      else if (b >= "A" && b <= "F") d = b - "A" + 10;
      else begin
        size_stop = 1'b1;
        return;
      end
      if (size_val > ((size_max - d) >> 4)) size_val = size_max;
      else size_val = (size_val << 4) + d;
    endfunction

    function void data_step(logic [7:0] b);
      remaining = remaining - 64'd1;
      if (remaining == 0) chunk = CH_CR;
      if (b == CHR_LF) begin
        if (ln_pass) emit(KIND_EOL, 8'h00, ERR_NONE);
        open_line();
      end else if (ln_start) begin
        ln_start = 1'b0;
        ln_pass  = 1'b0;
        ln_cr    = 1'b0;
        if (b == CHR_BRACE) begin
          ln_pass = 1'b1;
          emit(KIND_BYTE, b, ERR_NONE);
        end
      end else if (ln_pass) begin
        // a held CR turns out to be data once anything but LF follows it
        if (ln_cr) emit(KIND_BYTE, CHR_CR, ERR_NONE);
        if (b == CHR_CR) ln_cr = 1'b1;
        else begin
          ln_cr = 1'b0;
          emit(KIND_BYTE, b, ERR_NONE);
        end
      end
    endfunction

    // Note an accepted request and queue the results it causes.
    function void note_request(chre_in_t item);
      n_requests++;
      if (item.mode) begin
        n_restarts++;
        begin_response();
        return;
      end
      case (phase)
        PH_HEADER: header_byte(item.data_byte);
        PH_STREAM: begin
          case (chunk)
            CH_SIZE: size_byte(item.data_byte);
            CH_DATA: data_step(item.data_byte);
            CH_CR:   if (item.data_byte == CHR_CR) chunk = CH_LF;
            default: begin
              if (item.data_byte == CHR_LF) begin
                if (ln_pass) emit(KIND_EOL, 8'h00, ERR_NONE);
                open_line();
                chunk     = CH_SIZE;
                remaining = '0;
              end
            end
          endcase
        end
        default: ;
      endcase
      if (held_on) begin
        held_ev.last = 1'b1;
        events_due.push_back(held_ev);
        held_on = 1'b0;
      end
    endfunction

    function void match_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        n_fail++;
      end
    endfunction

    // Check one accepted result against the oldest outstanding one.
    function void check_result(chre_out_t got);
      chre_out_t want;
      n_results++;
      if (events_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d payload %02h code %0d last %0d",
                 $time, got.kind, got.payload, got.error_code, got.last);
        n_fail++;
        return;
      end
      want = events_due.pop_front();
      if (want.kind == KIND_EOL) n_lines++;
      if (want.kind == KIND_ERR) n_errors++;
      match_field("kind", want.kind, got.kind);
      match_field("payload", want.payload, got.payload);
      match_field("error_code", want.error_code, got.error_code);
      match_field("last", want.last, got.last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  chre_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  chre_out_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_addr  = CFG_HEADER_LIMIT;
  logic [15:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  http_chunked_response_line_extractor_top #(
    .SIZE_WIDTH(SIZE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  chunk_line_tracker #(SIZE_BITS) board;
  chre_in_t stim_q[$];
  bit       idling_on  = 1'b1;
  bit       in_calm    = 1'b0;
  bit       out_calm   = 1'b0;
  int       out_hold   = 0;
  int       out_cycles = 0;
  int       sent       = 0;
  int       n_settings = 0;

  // --------------------------------------------------------------------------
  // Result side: stall in random bursts, with calm stretches.
  // Results are sampled mid-cycle, where every signal has settled, and count
  // as taken at the following rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!idling_on || out_calm) begin
      out_hold = 0;
      out_stall <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    out_cycles++;
    if (out_cycles % 80 == 0) out_calm = ($urandom_range(0, 3) == 0);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Drive one request and hold it until the block takes it. A gap, when one is
  // drawn, drops valid first; otherwise valid stays high from the last request,
  // so valid never sees two assignments in one step.
  task automatic send_item(input chre_in_t item);
    int gap;
    if (idling_on && !in_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    board.note_request(item);
    @(posedge clk);
    sent++;
    if (sent % 64 == 0) in_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic run_stim();
    chre_in_t item;
    while (stim_q.size() != 0) begin
      item = stim_q.pop_front();
      send_item(item);
    end
  endtask

  // Drop valid, wait for every outstanding result, then keep idling so that a
  // byte without a result has surely been absorbed.
  task automatic settle();
    int wait_cnt;
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (board.events_due.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write both limits on back-to-back edges; only ever called while idle.
  task automatic set_limits(input logic [15:0] hdr, input logic [11:0] size);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_HEADER_LIMIT;
    cfg_wdata <= hdr;
    @(posedge clk);
    cfg_addr  <= CFG_SIZE_LIMIT;
    cfg_wdata <= {4'd0, size};
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_limits(hdr, size);
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Response builders: append requests to the stimulus queue
  // --------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b);
    chre_in_t it;
    it.mode      = 1'b0;
    it.data_byte = b;
    stim_q.push_back(it);
  endtask

  task automatic put_restart();
    chre_in_t it;
    it.mode      = 1'b1;
    it.data_byte = 8'($urandom_range(0, 255));
    stim_q.push_back(it);
  endtask

  task automatic put_crlf();
    put_byte(CHR_CR);
    put_byte(CHR_LF);
  endtask

  // Append text, flipping the case of letters at random when asked.
  task automatic put_text(input string s, input bit mix_case);
    int         i;
    logic [7:0] c;
    for (i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
          $urandom_range(0, 1) == 1)
        c = c ^ 8'h20;
      put_byte(c);
    end
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // The transfer-encoding line: mostly good, sometimes subtly wrong.
  task automatic put_te_line();
    case ($urandom_range(0, 19))
      0:       put_text("Transfer-Encoding: gzip", 1);
      1:       put_text("Transfer-Encoding: chunkd", 1);
      2:       put_text("X-Transfer-Encoding: chunked", 1);
      3:       put_text("Content-Length: 12", 1);
      4:       put_text("Transfer-Encoding: gzip, chunked", 1);
      5:       put_text("Transfer-Encoding:cchunked", 1);
      default: put_text("Transfer-Encoding: chunked", 1);
    endcase
    put_crlf();
  endtask

  task automatic put_filler_line(input bit bare_ok);
    case ($urandom_range(0, 4))
      0:       put_text("Host: example.org", 1);
      1:       put_text("Content-Type: application/json", 1);
      2:       put_text("Transfer: chunked", 1);
      3:       put_text("Transfer-Encodin: chunked", 1);
      default: put_text("Cache-Control: no-cache", 1);
    endcase
    if (bare_ok && $urandom_range(0, 6) == 0) put_byte(CHR_LF);
    else put_crlf();
  endtask

  // Size line for a chunk of len bytes, in mixed case, sometimes padded with
  // a leading zero and followed by something that ends the digits.
  task automatic put_size_line(input int len);
    string s;
    int    r;
    s = $sformatf("%0h", len);
    if ($urandom_range(0, 5) == 0) s = {"0", s};
    put_text(s, 1);
    r = $urandom_range(0, 9);
    if (r == 0) put_text(";ext=1", 0);
    else if (r == 1) put_byte(CHR_LF);
    else if (r == 2) begin
      put_byte(CHR_CR);
      put_text("x", 0);
    end
    put_crlf();
  endtask

  // Chunk body: short lines, about half of them opening with a brace, with
  // stray CRs, CRLF and bare LF endings and the odd arbitrary byte.
  task automatic put_chunk_data(input int len);
    int         i;
    int         r;
    bit         at_start;
    bit         prev_cr;
    logic [7:0] b;
    at_start = 1'b1;
    prev_cr  = 1'b0;
    for (i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (prev_cr && r < 50) b = CHR_LF;
      else if (at_start && r < 55) b = CHR_BRACE;
      else if (r < 6) b = CHR_CR;
      else if (r < 12) b = CHR_LF;
      else if (r < 16) b = 8'($urandom_range(0, 255));
      else b = printable();
      put_byte(b);
      at_start = (b == CHR_LF);
      prev_cr  = (b == CHR_CR);
    end
  endtask

  // Chunk trailer: CRLF, or junk before the CR, or junk between CR and LF.
  task automatic put_trailer();
    int r;
    r = $urandom_range(0, 9);
    if (r == 8) repeat ($urandom_range(1, 3)) put_byte(printable());
    put_byte(CHR_CR);
    if (r == 9) repeat ($urandom_range(1, 3)) put_byte(printable());
    put_byte(CHR_LF);
  endtask

  // Bad size lines: a hex prefix, a leading space or an empty line all give
  // size zero; nine digits saturate, and the data is then cut by a restart.
  task automatic put_broken_size();
    case ($urandom_range(0, 3))
      0: begin
        put_text("0x1f", 0);
        put_crlf();
      end
      1: begin
        put_text(" 1a", 0);
        put_crlf();
      end
      2: begin
        put_text("fffffffff", 1);
        put_crlf();
        put_chunk_data($urandom_range(3, 20));
      end
      default: put_crlf();
    endcase
  endtask

  task automatic gen_response();
    int r;
    int i;
    int n_fill;
    int te_at;
    int n_chunks;
    int len;
    r = $urandom_range(0, 99);
    // stray bytes with no restart: land wherever the block happens to be
    if (r < 5) begin
      repeat ($urandom_range(3, 20)) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    put_restart();
    if (r < 12) begin
      repeat ($urandom_range(5, 30)) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 19))
      0:       put_text("HTTP/1.1 404 Not Found", 1);
      1:       put_text("HTTP/1.1 500 Internal Error", 1);
      2:       put_text("HTTP/1.1 2000 Odd", 1);
      default: put_text("HTTP/1.1 200 OK", 1);
    endcase
    put_crlf();
    n_fill = $urandom_range(0, 3);
    te_at  = $urandom_range(0, n_fill);
    for (i = 0; i <= n_fill; i++) begin
      if (i == te_at) put_te_line();
      else put_filler_line(i < n_fill);
    end
    put_crlf();
    n_chunks = $urandom_range(1, 3);
    for (i = 0; i < n_chunks; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        put_broken_size();
        return;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      put_size_line(len);
      put_chunk_data(len);
      put_trailer();
    end
    // the closing zero-size chunk ends the stream with its own error
    if ($urandom_range(0, 9) < 7) begin
      put_text("0", 0);
      put_crlf();
      put_crlf();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    int p;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bytes before any restart find the block idle; nothing comes out.
    put_byte(8'h00);
    put_byte(8'hFF);
    run_stim();
    settle();

    // Smallest header limit: the fifth header byte overflows it, and bytes
    // after the error are dropped. Then a bare CRLFCRLF lacks a 200 status.
    set_limits(16'd4, 12'd1);
    put_restart();
    put_text("200", 0);
    put_crlf();
    put_byte("A");
    put_restart();
    put_crlf();
    put_crlf();
    run_stim();
    settle();

    // Largest limits: a header with a 200 status but no chunked encoding.
    set_limits(16'hFFFF, 12'd4095);
    put_restart();
    put_text("200", 0);
    put_crlf();
    put_crlf();
    run_stim();

    // Random phases, each under its own limit setting; the last one runs
    // without idling on either side.
    for (p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: set_limits(16'hFFFF, 12'd4095);
        1: set_limits(16'($urandom_range(24, 160)), 12'd1);
        2: set_limits(HEADER_LIMIT_RST, SIZE_LIMIT_RST);
        3: set_limits(16'($urandom_range(4, 65535)), 12'($urandom_range(1, 4095)));
        default: begin
          set_limits(16'($urandom_range(60, 400)), 12'($urandom_range(2, 3)));
          idling_on = 1'b0;
        end
      endcase
      while (stim_q.size() < 300) gen_response();
      run_stim();
    end

    settle();
    repeat (4) @(posedge clk);
    if (board.events_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.events_due.size());
      board.n_fail++;
    end
    $display("Drove %0d requests, %0d of them restarts, under %0d limit settings.",
             board.n_requests, board.n_restarts, n_settings);
    $display("Checked %0d results: %0d line ends and %0d stream errors; %0d mismatches.",
             board.n_results, board.n_lines, board.n_errors, board.n_fail);
    if (board.n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop for the whole run.
  initial begin
    #5000000;
    $display("Run timed out with %0d results outstanding", board.events_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
